// ===== rtl/mcpi_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpi_pkg
// Types, constants and the xorshift32 step shared by the hit counter modules.
// ----------------------------------------------------------------------------
package mcpi_pkg;

  localparam int unsigned SEED_W     = 32;
  localparam int unsigned FRAC_W     = 23;
  localparam int unsigned SQ_W       = 2 * FRAC_W;
  localparam int unsigned BHITS_W    = 4;
  localparam int unsigned THITS_W    = 48;

  localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;
  // 1.0 squared in Q0.46, compared against a 47-bit sum of squares
  localparam logic [SQ_W:0]     ONE_SQ     = 47'h1 << SQ_W;

  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 17;
  localparam int unsigned XS_C = 5;

  typedef struct packed {
    logic restart;
    logic last_batch;
  } mcpi_in_t;

  typedef struct packed {
    logic [BHITS_W-1:0] batch_hits;
    logic [THITS_W-1:0] run_total;
    logic               done_res;
  } mcpi_out_t;

  // per-stage load enables and the restart select, handed to every lane
  typedef struct packed {
    logic ld_en;
    logic restart;
    logic sq_en;
    logic cmp_en;
  } mcpi_ctl_t;

  function automatic logic [SEED_W-1:0] xs32(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] t;
    t = s ^ (s << XS_A);
    t = t ^ (t >> XS_B);
    t = t ^ (t << XS_C);
    return t;
  endfunction

endpackage

// ===== rtl/mcpi_lane.sv =====
// ----------------------------------------------------------------------------
// mcpi_lane
// One generator lane: xorshift32 state, coordinate, square and compare stages.
// ----------------------------------------------------------------------------
module mcpi_lane import mcpi_pkg::*; #(
  parameter logic [31:0] RESET_SEED = 32'd1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcpi_ctl_t         ctl_i,
  input  logic [SEED_W-1:0] seed_i,
  output logic              hit_o
);

  logic [SEED_W-1:0] state_q, state_d;
  logic [SEED_W-1:0] sx, sy, s_cur;
  logic [FRAC_W-1:0] mx_q, my_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q;
  logic [SQ_W:0]     sq_sum;
  logic              hit_q;

  always_comb begin
    s_cur   = ctl_i.restart ? seed_i : state_q;
    sx      = xs32(s_cur);
    sy      = xs32(sx);
    state_d = sy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RESET_SEED;
    end else if (ctl_i.ld_en) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_en) begin
      mx_q <= sx[FRAC_W-1:0];
      my_q <= sy[FRAC_W-1:0];
    end
    if (ctl_i.sq_en) begin
      sqx_q <= {{FRAC_W{1'b0}}, mx_q} * {{FRAC_W{1'b0}}, mx_q};
      sqy_q <= {{FRAC_W{1'b0}}, my_q} * {{FRAC_W{1'b0}}, my_q};
    end
    if (ctl_i.cmp_en) begin
      hit_q <= (sq_sum <= ONE_SQ);
    end
  end

  assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign hit_o  = hit_q;

endmodule

// ===== rtl/mcpi_accum.sv =====
// ----------------------------------------------------------------------------
// mcpi_accum
// Counts the hits of a batch and keeps the saturating running total.
// ----------------------------------------------------------------------------
module mcpi_accum import mcpi_pkg::*; #(
  parameter int unsigned LANES       = 8,
  parameter int unsigned TOTAL_WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             restart_i,
  input  logic             last_i,
  input  logic [LANES-1:0] hits_i,
  output mcpi_out_t        out_o
);

  localparam int unsigned CntW = $clog2(LANES + 1);

  logic [CntW-1:0]        cnt;
  logic [CntW+BHITS_W-1:0] cnt_x;
  logic [TOTAL_WIDTH:0]   sum;
  logic [TOTAL_WIDTH-1:0] base;
  logic [TOTAL_WIDTH-1:0] total_q, total_d;
  logic [63:0]            total_x;
  logic [BHITS_W-1:0]     bhits_q;
  logic                   done_q;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < LANES; i++) begin
      cnt = cnt + CntW'(hits_i[i]);
    end
  end

  // restart clears the total before this batch is added
  assign base  = restart_i ? '0 : total_q;
  assign sum   = {1'b0, base} + (TOTAL_WIDTH + 1)'(cnt);
  assign total_d = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
  assign cnt_x = (CntW + BHITS_W)'(cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (en_i) begin
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bhits_q <= cnt_x[BHITS_W-1:0];
      done_q  <= last_i;
    end
  end

  assign total_x          = 64'(total_q);
  assign out_o.batch_hits = bhits_q;
  assign out_o.run_total  = total_x[THITS_W-1:0];
  assign out_o.done_res   = done_q;

endmodule

// ===== rtl/monte_carlo_pi_hit_counter.sv =====
// ----------------------------------------------------------------------------
// monte_carlo_pi_hit_counter
// Parallel xorshift32 lanes draw one point each per batch; counts the points
// inside the quarter circle and keeps a saturating running total.
// ----------------------------------------------------------------------------
//  channel   signals                        direction
//  input     in_valid_i/in_stall_o/in_data_i    in   one batch per beat
//  output    out_valid_o/out_stall_i/out_data_o out  one result per beat
//  config    cfg_we_i/cfg_data_i                in   base seed, no read-back
//
//  One batch per cycle sustained while the output is not stalled; a result
//  passes the coordinate, square, compare and count/total registers in turn,
//  the first one loaded on the edge that accepts its beat.
//  Lane states step at input acceptance, so the state loop holds two chained
//  xorshift rounds. Reset loads lane k with 1 + k and clears the total.
//  Stalls back up stage by stage; bubbles are squeezed out before the input
//  stalls, so up to four batches are held while the output is stalled.
// ----------------------------------------------------------------------------
module monte_carlo_pi_hit_counter import mcpi_pkg::*; #(
  parameter int unsigned LANES       = 8,
  parameter int unsigned TOTAL_WIDTH = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SEED_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mcpi_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mcpi_out_t         out_data_o
);

  logic [SEED_W-1:0] seed_cfg_q;
  logic v1_q, v2_q, v3_q, ov_q;
  logic r1_q, r2_q, r3_q;
  logic l1_q, l2_q, l3_q;
  logic en0, en1, en2, en3;
  logic free1, free2, free3, free_out;
  logic [LANES-1:0] hits;
  mcpi_ctl_t ctl;

  assign free_out = !ov_q || !out_stall_i;
  assign en3      = v3_q && free_out;
  assign free3    = !v3_q || en3;
  assign en2      = v2_q && free3;
  assign free2    = !v2_q || en2;
  assign en1      = v1_q && free2;
  assign free1    = !v1_q || en1;
  assign en0      = in_valid_i && free1;

  assign in_stall_o = !free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_cfg_q <= SEED_RESET;
    end else if (cfg_we_i) begin
      seed_cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      v1_q <= en0 || (v1_q && !en1);
      v2_q <= en1 || (v2_q && !en2);
      v3_q <= en2 || (v3_q && !en3);
      ov_q <= en3 || (ov_q && out_stall_i);
    end
  end

  // restart and last travel beside the lane pipeline
  always_ff @(posedge clk_i) begin
    if (en0) begin
      r1_q <= in_data_i.restart;
      l1_q <= in_data_i.last_batch;
    end
    if (en1) begin
      r2_q <= r1_q;
      l2_q <= l1_q;
    end
    if (en2) begin
      r3_q <= r2_q;
      l3_q <= l2_q;
    end
  end

  assign ctl.ld_en   = en0;
  assign ctl.restart = in_data_i.restart;
  assign ctl.sq_en   = en1;
  assign ctl.cmp_en  = en2;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mcpi_lane #(
      .RESET_SEED(SEED_RESET + 32'(k))
    ) u_lane (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .seed_i(seed_cfg_q + 32'(k)),
      .hit_o (hits[k])
    );
  end

  mcpi_accum #(
    .LANES      (LANES),
    .TOTAL_WIDTH(TOTAL_WIDTH)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en3),
    .restart_i(r3_q),
    .last_i   (l3_q),
    .hits_i   (hits),
    .out_o    (out_data_o)
  );

  assign out_valid_o = ov_q;

endmodule

// ===== rtl/mcpi_checker.sv =====
// ----------------------------------------------------------------------------
// mcpi_checker
// Port-level checks for the hit counter, bound to the top level.
// ----------------------------------------------------------------------------
module mcpi_checker import mcpi_pkg::*; #(
  parameter int unsigned LANES       = 8,
  parameter int unsigned TOTAL_WIDTH = 48
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic [SEED_W-1:0] cfg_data_i,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input mcpi_in_t          in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mcpi_out_t         out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled output beat changed");

  // an empty output slot means every stage can move
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with output empty");

  a_hits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && LANES <= 15 |-> out_data_o.batch_hits <= LANES)
    else $error("batch hits above lane count");

  a_total_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && TOTAL_WIDTH <= THITS_W |->
      out_data_o.run_total >= THITS_W'(out_data_o.batch_hits))
    else $error("total below batch hits");

endmodule

bind monte_carlo_pi_hit_counter mcpi_checker #(
  .LANES      (LANES),
  .TOTAL_WIDTH(TOTAL_WIDTH)
) u_mcpi_checker (.*);

// ===== test/mcpi_hit_checker.sv =====
// ----------------------------------------------------------------------------
// mcpi_hit_checker
// Watches the seed port and both channels of the hit counter. Each batch
// taken in is scored by a model of its own, and each result that leaves is
// compared field by field against the oldest queued score.
// ----------------------------------------------------------------------------
module mcpi_hit_checker import mcpi_pkg::*; #(
  parameter int unsigned LANES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SEED_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  mcpi_in_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  mcpi_out_t         out_data_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       pending_o
);

  localparam logic [THITS_W-1:0] TOTAL_MAX   = '1;
  localparam logic [SQ_W:0]      UNIT_SQ     = {1'b1, {SQ_W{1'b0}}};

  logic [SEED_W-1:0]  seed_q;
  logic [SEED_W-1:0]  lane_q [LANES];
  logic [THITS_W-1:0] total_q;
  mcpi_out_t          score_q [$];
  int unsigned        mismatches;

  function automatic logic [SEED_W-1:0] xorshift_step(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] t;
    t = s ^ (s << XS_A);
    t = t ^ (t >> XS_B);
    t = t ^ (t << XS_C);
    return t;
  endfunction

  task automatic reload_lanes();
    for (int unsigned k = 0; k < LANES; k++) begin
      lane_q[k] = seed_q + SEED_W'(k);
    end
  endtask

  // Advances every lane twice and scores the batch against the unit circle.
  task automatic score_batch(input mcpi_in_t beat, output mcpi_out_t res);
    logic [SEED_W-1:0]  sx, sy;
    logic [SQ_W:0]      mx, my;
    logic [BHITS_W-1:0] hits;
    if (beat.restart) begin
      reload_lanes();
      total_q = '0;
    end
    hits = '0;
    for (int unsigned k = 0; k < LANES; k++) begin
      sx = xorshift_step(lane_q[k]);
      sy = xorshift_step(sx);
      lane_q[k] = sy;
      mx = (SQ_W+1)'(sx[FRAC_W-1:0]);
      my = (SQ_W+1)'(sy[FRAC_W-1:0]);
      if (mx * mx + my * my <= UNIT_SQ) begin
        hits++;
      end
    end
    if (THITS_W'(hits) > TOTAL_MAX - total_q) begin
      total_q = TOTAL_MAX;
    end else begin
      total_q = total_q + THITS_W'(hits);
    end
    res.batch_hits = hits;
    res.run_total  = total_q;
    res.done_res   = beat.last_batch;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    mcpi_out_t want;
    if (!rst_ni) begin
      seed_q  = SEED_RESET;
      total_q = '0;
      reload_lanes();
      score_q.delete();
      mismatches = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        score_batch(in_data_i, want);
        score_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (score_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no batch pending: expected none, actual %h",
                   $time, out_data_i);
        end else begin
          want = score_q.pop_front();
          check_field("batch_hits", 64'(want.batch_hits), 64'(out_data_i.batch_hits));
          check_field("run_total",  64'(want.run_total),  64'(out_data_i.run_total));
          check_field("done_res",   64'(want.done_res),   64'(out_data_i.done_res));
        end
      end
      // a seed write lands in the register only after this edge
      if (cfg_we_i) begin
        seed_q = cfg_data_i;
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= score_q.size();
  end

endmodule

// ===== test/tb_monte_carlo_pi_hit_counter.sv =====
// ----------------------------------------------------------------------------
// tb_monte_carlo_pi_hit_counter
// Drives batches in bursts against a stalling receiver, under several seeds
// including all-zero and all-one, and hands every beat to the checker, which
// scores each batch and compares the results.
// ----------------------------------------------------------------------------
module tb_monte_carlo_pi_hit_counter;
  import mcpi_pkg::*;

  localparam int unsigned ITEM_TARGET   = 2000;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_e;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [SEED_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  mcpi_in_t          in_data;
  logic              out_valid;
  logic              out_stall;
  mcpi_out_t         out_data;
  int unsigned       mismatch_cnt;
  int unsigned       pending;
  int unsigned       burst_left;
  int unsigned       beats_sent;
  int unsigned       cycles;

  monte_carlo_pi_hit_counter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  mcpi_hit_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_monte_carlo_pi_hit_counter: errors");
    $finish;
  end

  // Receiver stall pattern; every seventh stretch is a long hold-off.
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned seg_len;
    int unsigned seg_idx;
    out_stall = 1'b0;
    seg_idx   = 0;
    @(posedge rst_n);
    forever begin
      seg_idx++;
      if (seg_idx % 7 == 3) begin
        mode    = RX_HOLD;
        seg_len = 64;
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 2));
        seg_len = $urandom_range(10, 120);
      end
      repeat (seg_len) begin
        @(negedge clk);
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:  out_stall <= 1'b1;
        endcase
      end
    end
  end

  task automatic send_batch(input logic restart, input logic last);
    int unsigned gap;
    @(negedge clk);
    in_valid           <= 1'b1;
    in_data.restart    <= restart;
    in_data.last_batch <= last;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Stop offering and wait until every scored batch has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [SEED_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [SEED_W-1:0] seed;
    int unsigned       run_len;
    int unsigned       phase_left;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    burst_left = 4;
    beats_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // lanes straight out of reset, then restarts on the reset seed
    send_batch(1'b0, 1'b0);
    send_batch(1'b0, 1'b0);
    send_batch(1'b0, 1'b1);
    send_batch(1'b1, 1'b0);
    send_batch(1'b1, 1'b1);
    send_batch(1'b0, 1'b0);
    drain();

    // seed zero: lane 0 sticks at zero and hits every batch
    write_seed('0);
    send_batch(1'b1, 1'b0);
    send_batch(1'b0, 1'b0);
    send_batch(1'b0, 1'b1);
    drain();

    // all-ones seed wraps lane 1 to zero
    write_seed('1);
    send_batch(1'b1, 1'b0);
    send_batch(1'b0, 1'b0);
    send_batch(1'b0, 1'b1);
    drain();

    // new seed must not disturb the run until the next restart
    write_seed(32'h8000_0000);
    send_batch(1'b0, 1'b0);
    send_batch(1'b0, 1'b0);
    send_batch(1'b1, 1'b0);
    send_batch(1'b0, 1'b1);
    drain();

    // runs: restart on most first beats, last_batch on the closing beat, some noise
    while (beats_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0:       seed = '0;
        1:       seed = '1;
        2:       seed = SEED_RESET;
        default: seed = $urandom;
      endcase
      write_seed(seed);
      phase_left = $urandom_range(40, 300);
      while (phase_left > 0 && beats_sent < ITEM_TARGET) begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 24);
        for (int unsigned i = 0; i < run_len; i++) begin
          send_batch((i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 49) == 0),
                     (i == run_len - 1) ? 1'b1 : ($urandom_range(0, 15) == 0));
        end
        phase_left = (run_len >= phase_left) ? 0 : phase_left - run_len;
        if ($urandom_range(0, 9) == 0) begin
          drain();
        end
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("tb_monte_carlo_pi_hit_counter: clean");
    end else begin
      $display("tb_monte_carlo_pi_hit_counter: errors");
    end
    $finish;
  end

endmodule
